@@ design/dtfp_pkg.sv @@
// types, constants and control program shared by the decimal text parser
`default_nettype none

package dtfp_pkg;

  localparam int CH_W     = 8;
  localparam int MANT_W   = 60;
  localparam int LIMIT_W  = 30;
  localparam int VALUE_W  = 31;
  localparam int STATUS_W = 2;
  localparam int DCNT_W   = 5;

  localparam int MAX_DIGITS_DEF    = 18;
  localparam int FRACTION_BITS_DEF = 28;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 30'd536870912;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NODIGIT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_DOT   = 8'h2e;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0d;

  typedef enum logic [2:0] {
    PH_SKIP,
    PH_SIGN,
    PH_INT,
    PH_FRAC,
    PH_REST,
    PH_BAD
  } phase_t;

  // jump conditions of the control program
  typedef enum logic [1:0] {
    C_LAST,
    C_BAD,
    C_MORE,
    C_OUTFREE
  } cond_t;

  typedef logic [1:0] step_t;

  localparam step_t STEP_PARSE = 2'd0;
  localparam step_t STEP_LOAD  = 2'd1;
  localparam step_t STEP_DIV   = 2'd2;
  localparam step_t STEP_EMIT  = 2'd3;

  typedef struct packed {
    logic  in_en;
    logic  load;
    logic  div;
    logic  emit;
    cond_t cond;
    step_t tgt;
    logic  hold;
  } ctrl_t;

  typedef struct packed {
    logic last_acc;
    logic bad;
    logic out_free;
  } flags_t;

  // control store: condition true jumps to tgt, else hold or fall through
  function automatic ctrl_t ucode(input step_t s);
    ctrl_t w;
    w = '0;
    case (s)
      STEP_PARSE: begin
        w.in_en = 1'b1;
        w.cond  = C_LAST;
        w.tgt   = STEP_LOAD;
        w.hold  = 1'b1;
      end
      STEP_LOAD: begin
        w.load = 1'b1;
        w.cond = C_BAD;
        w.tgt  = STEP_EMIT;
        w.hold = 1'b0;
      end
      STEP_DIV: begin
        w.div  = 1'b1;
        w.cond = C_MORE;
        w.tgt  = STEP_DIV;
        w.hold = 1'b0;
      end
      STEP_EMIT: begin
        w.emit = 1'b1;
        w.cond = C_OUTFREE;
        w.tgt  = STEP_PARSE;
        w.hold = 1'b1;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [MANT_W-1:0] pow10(input logic [DCNT_W-1:0] n);
    logic [MANT_W-1:0] p;
    case (n)
      5'd0:    p = 60'd1;
      5'd1:    p = 60'd10;
      5'd2:    p = 60'd100;
      5'd3:    p = 60'd1000;
      5'd4:    p = 60'd10000;
      5'd5:    p = 60'd100000;
      5'd6:    p = 60'd1000000;
      5'd7:    p = 60'd10000000;
      5'd8:    p = 60'd100000000;
      5'd9:    p = 60'd1000000000;
      5'd10:   p = 60'd10000000000;
      5'd11:   p = 60'd100000000000;
      5'd12:   p = 60'd1000000000000;
      5'd13:   p = 60'd10000000000000;
      5'd14:   p = 60'd100000000000000;
      5'd15:   p = 60'd1000000000000000;
      5'd16:   p = 60'd10000000000000000;
      5'd17:   p = 60'd100000000000000000;
      default: p = 60'd1000000000000000000;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

@@ design/dtfp_in_if.sv @@
// character input channel
`default_nettype none

interface dtfp_in_if;
  logic                     valid;
  logic                     ready;
  logic [dtfp_pkg::CH_W-1:0] ch;
  logic                     last;

  modport source (output valid, output ch, output last, input ready);
  modport sink   (input valid, input ch, input last, output ready);
endinterface

`default_nettype wire

@@ design/dtfp_out_if.sv @@
// result output channel
`default_nettype none

interface dtfp_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [dtfp_pkg::VALUE_W-1:0] value;
  logic [dtfp_pkg::STATUS_W-1:0]       status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

@@ design/decimal_text_to_fixed_point_top.sv @@
// top level: ascii decimal text to signed fixed point converter
//
//  channel   direction  payload                   transfer
//  in_bus    in         ch[7:0], last             valid & ready
//  out_bus   out        value[30:0], status[1:0]  valid & ready
//  cfg       in         cfg_wdata[29:0]           cfg_we
//
// one character per cycle while parsing; in_bus.ready is high in the parse step
// the character marked last starts the one-bit-per-cycle restoring divider; no new
//   character is taken until its result has been emitted; the divider is skipped
//   when no digit was seen
// the emit step waits while out_bus still holds an untaken result
// reset is synchronous active low; clears parser, sequencer and output valid, limit back to 2.0
`default_nettype none

module decimal_text_to_fixed_point_top #(
  parameter int MAX_DIGITS    = dtfp_pkg::MAX_DIGITS_DEF,
  parameter int FRACTION_BITS = dtfp_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  dtfp_in_if.sink                           in_bus,
  dtfp_out_if.source                        out_bus,
  input  wire logic                         cfg_we,
  input  wire logic [dtfp_pkg::LIMIT_W-1:0] cfg_wdata
);

  dtfp_pkg::ctrl_t  ctrl;
  dtfp_pkg::flags_t flags;

  dtfp_seq #(
    .DIV_STEPS(dtfp_pkg::MANT_W + FRACTION_BITS)
  ) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctrl  (ctrl)
  );

  dtfp_dp #(
    .MAX_DIGITS    (MAX_DIGITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .flags      (flags),
    .in_valid   (in_bus.valid),
    .in_ch      (in_bus.ch),
    .in_last    (in_bus.last),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_ready  (out_bus.ready),
    .out_valid  (out_bus.valid),
    .out_value  (out_bus.value),
    .out_status (out_bus.status)
  );

  assign in_bus.ready = ctrl.in_en;

endmodule

`default_nettype wire

@@ design/dtfp_seq.sv @@
// step counter, control store and iteration counter
`default_nettype none

module dtfp_seq #(
  parameter int DIV_STEPS = dtfp_pkg::MANT_W + dtfp_pkg::FRACTION_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire dtfp_pkg::flags_t flags,
  output dtfp_pkg::ctrl_t       ctrl
);

  localparam int CNT_W = $clog2(DIV_STEPS + 1);

  dtfp_pkg::step_t  step_r, step_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             more;
  logic             cond_hit;

  assign ctrl = dtfp_pkg::ucode(step_r);
  assign more = (cnt_r != CNT_W'(1));

  always_comb begin
    case (ctrl.cond)
      dtfp_pkg::C_LAST:    cond_hit = flags.last_acc;
      dtfp_pkg::C_BAD:     cond_hit = flags.bad;
      dtfp_pkg::C_MORE:    cond_hit = more;
      dtfp_pkg::C_OUTFREE: cond_hit = flags.out_free;
      default:             cond_hit = 1'b0;
    endcase

    if (cond_hit) begin
      step_nxt = ctrl.tgt;
    end else if (ctrl.hold) begin
      step_nxt = step_r;
    end else begin
      step_nxt = step_r + dtfp_pkg::step_t'(1);
    end

    cnt_nxt = cnt_r;
    if (ctrl.load) begin
      cnt_nxt = CNT_W'(DIV_STEPS);
    end else if (ctrl.div) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= dtfp_pkg::STEP_PARSE;
      cnt_r  <= '0;
    end else begin
      step_r <= step_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/dtfp_dp.sv @@
// datapath: character parser, bit-serial divider and output register
`default_nettype none

module dtfp_dp #(
  parameter int MAX_DIGITS    = dtfp_pkg::MAX_DIGITS_DEF,
  parameter int FRACTION_BITS = dtfp_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire dtfp_pkg::ctrl_t                     ctrl,
  output dtfp_pkg::flags_t                         flags,
  input  wire logic                                in_valid,
  input  wire logic [dtfp_pkg::CH_W-1:0]           in_ch,
  input  wire logic                                in_last,
  input  wire logic                                cfg_we,
  input  wire logic [dtfp_pkg::LIMIT_W-1:0]        cfg_wdata,
  input  wire logic                                out_ready,
  output logic                                     out_valid,
  output logic signed [dtfp_pkg::VALUE_W-1:0]      out_value,
  output logic [dtfp_pkg::STATUS_W-1:0]            out_status
);

  localparam int MW = dtfp_pkg::MANT_W;
  localparam int VW = dtfp_pkg::VALUE_W;
  localparam int DW = dtfp_pkg::DCNT_W;
  localparam int DIV_STEPS = MW + FRACTION_BITS;

  logic [dtfp_pkg::LIMIT_W-1:0] limit_r;

  dtfp_pkg::phase_t phase_r, phase_nxt;
  logic             neg_r, neg_nxt;
  logic [MW-1:0]    mant_r, mant_nxt;
  logic [DW-1:0]    dig_r, dig_nxt;
  logic [DW-1:0]    fdig_r, fdig_nxt;

  logic [MW-1:0]        p_r, p_nxt;
  logic [MW-1:0]        rem_r, rem_nxt;
  logic [DIV_STEPS-1:0] dvd_r, dvd_nxt;
  logic [VW-1:0]        q_r, q_nxt;
  logic                 ovf_r, ovf_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [VW-1:0]                 out_value_r, out_value_nxt;
  logic [dtfp_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;

  logic          acc;
  logic          is_digit, is_space;
  logic [3:0]    dval;
  logic [MW-1:0] mant_mac;
  logic          dig_full;
  logic          int_skip;
  logic [MW-1:0] int_mant;
  logic [DW-1:0] int_dig;
  logic          bad;
  logic          out_free;
  logic          emit_now;
  logic          over;
  logic [MW:0]   shifted;
  logic [MW+1:0] diff;
  logic          qbit;

  assign acc      = ctrl.in_en && in_valid;
  assign is_digit = in_ch inside {[dtfp_pkg::CH_ZERO:dtfp_pkg::CH_NINE]};
  assign is_space = (in_ch == dtfp_pkg::CH_SPACE) ||
                    (in_ch inside {[dtfp_pkg::CH_TAB:dtfp_pkg::CH_CR]});
  assign dval     = 4'(in_ch - dtfp_pkg::CH_ZERO);
  assign mant_mac = (mant_r << 3) + (mant_r << 1) + MW'(dval);
  assign dig_full = (dig_r >= DW'(MAX_DIGITS));

  // leading integer zeros do not count as digits
  assign int_skip = (mant_r == '0) && (dval == 4'd0);
  always_comb begin
    if (int_skip) begin
      int_mant = mant_r;
      int_dig  = dig_r;
    end else if (dig_full) begin
      int_mant = '1;
      int_dig  = dig_r;
    end else begin
      int_mant = mant_mac;
      int_dig  = dig_r + DW'(1);
    end
  end

  assign bad      = phase_r inside {dtfp_pkg::PH_SKIP, dtfp_pkg::PH_SIGN, dtfp_pkg::PH_BAD};
  assign out_free = !out_valid_r || out_ready;
  assign emit_now = ctrl.emit && out_free;
  assign over     = ovf_r || (q_r > {1'b0, limit_r});

  assign flags.last_acc = acc && in_last;
  assign flags.bad      = bad;
  assign flags.out_free = out_free;

  // restoring divide step, one quotient bit per cycle
  assign shifted = {rem_r, dvd_r[DIV_STEPS-1]};
  assign diff    = {1'b0, shifted} - {2'b00, p_r};
  assign qbit    = !diff[MW+1];

  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    mant_nxt  = mant_r;
    dig_nxt   = dig_r;
    fdig_nxt  = fdig_r;

    if (emit_now) begin
      phase_nxt = dtfp_pkg::PH_SKIP;
      neg_nxt   = 1'b0;
      mant_nxt  = '0;
      dig_nxt   = '0;
      fdig_nxt  = '0;
    end else if (acc) begin
      case (phase_r)
        dtfp_pkg::PH_SKIP, dtfp_pkg::PH_SIGN: begin
          if (phase_r == dtfp_pkg::PH_SKIP && is_space) begin
            phase_nxt = phase_r;
          end else if (phase_r == dtfp_pkg::PH_SKIP && in_ch == dtfp_pkg::CH_MINUS) begin
            neg_nxt   = 1'b1;
            phase_nxt = dtfp_pkg::PH_SIGN;
          end else if (is_digit) begin
            mant_nxt  = int_mant;
            dig_nxt   = int_dig;
            phase_nxt = dtfp_pkg::PH_INT;
          end else begin
            phase_nxt = dtfp_pkg::PH_BAD;
          end
        end
        dtfp_pkg::PH_INT: begin
          if (is_digit) begin
            mant_nxt = int_mant;
            dig_nxt  = int_dig;
          end else if (in_ch == dtfp_pkg::CH_DOT) begin
            phase_nxt = dtfp_pkg::PH_FRAC;
          end else begin
            phase_nxt = dtfp_pkg::PH_REST;
          end
        end
        dtfp_pkg::PH_FRAC: begin
          if (!is_digit) begin
            phase_nxt = dtfp_pkg::PH_REST;
          end else if (!dig_full) begin
            mant_nxt = mant_mac;
            dig_nxt  = dig_r + DW'(1);
            fdig_nxt = fdig_r + DW'(1);
          end
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  always_comb begin
    p_nxt   = p_r;
    rem_nxt = rem_r;
    dvd_nxt = dvd_r;
    q_nxt   = q_r;
    ovf_nxt = ovf_r;
    if (ctrl.load) begin
      p_nxt   = dtfp_pkg::pow10(fdig_r);
      rem_nxt = '0;
      dvd_nxt = {mant_r, {FRACTION_BITS{1'b0}}};
      q_nxt   = '0;
      ovf_nxt = 1'b0;
    end else if (ctrl.div) begin
      rem_nxt = qbit ? diff[MW-1:0] : shifted[MW-1:0];
      dvd_nxt = {dvd_r[DIV_STEPS-2:0], 1'b0};
      q_nxt   = {q_r[VW-2:0], qbit};
      // any quotient bit past the top is out of range
      ovf_nxt = ovf_r || q_r[VW-1];
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    if (emit_now) begin
      out_valid_nxt = 1'b1;
      if (bad) begin
        out_status_nxt = dtfp_pkg::ST_NODIGIT;
        out_value_nxt  = '0;
      end else if (over) begin
        out_status_nxt = dtfp_pkg::ST_RANGE;
        out_value_nxt  = '0;
      end else begin
        out_status_nxt = dtfp_pkg::ST_OK;
        out_value_nxt  = neg_r ? (~q_r + VW'(1)) : q_r;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= dtfp_pkg::LIMIT_RESET;
      phase_r     <= dtfp_pkg::PH_SKIP;
      neg_r       <= 1'b0;
      mant_r      <= '0;
      dig_r       <= '0;
      fdig_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      phase_r     <= phase_nxt;
      neg_r       <= neg_nxt;
      mant_r      <= mant_nxt;
      dig_r       <= dig_nxt;
      fdig_r      <= fdig_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r          <= p_nxt;
    rem_r        <= rem_nxt;
    dvd_r        <= dvd_nxt;
    q_r          <= q_nxt;
    ovf_r        <= ovf_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;

endmodule

`default_nettype wire

@@ design/dtfp_checker.sv @@
// port-level checks for the converter, bound to the top level
`default_nettype none

module dtfp_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_valid,
  input wire logic                                in_ready,
  input wire logic                                in_last,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic signed [dtfp_pkg::VALUE_W-1:0] out_value,
  input wire logic [dtfp_pkg::STATUS_W-1:0]       out_status
);

  // result stays offered until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_status))
    else $error("result dropped or changed while stalled");

  // nothing left over from before reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // failed conversions carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != dtfp_pkg::ST_OK |-> out_value == '0)
    else $error("nonzero value with error status");

  // the final character starts the conversion, so input pauses
  a_last_pause: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("input taken right after final character");

endmodule

bind decimal_text_to_fixed_point_top dtfp_checker u_dtfp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_bus.valid),
  .in_ready   (in_bus.ready),
  .in_last    (in_bus.last),
  .out_valid  (out_bus.valid),
  .out_ready  (out_bus.ready),
  .out_value  (out_bus.value),
  .out_status (out_bus.status)
);

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// self-checking bench for the decimal text to fixed point converter
module testbench;

  localparam int WATCHDOG_CYCLES  = 5000;
  localparam int SETTLE_CYCLES    = 100;
  localparam int CHARS_PER_LIMIT  = 245;
  localparam int LIMIT_SETTINGS   = 6;
  localparam int RANDOM_LIMIT_IDX = 4;
  localparam int QUIET_SETTING    = 2;
  localparam int IDLE_PERCENT     = 21;
  localparam int PRINT_CAP        = 40;

  typedef logic [dtfp_pkg::CH_W-1:0]    char_t;
  typedef logic [dtfp_pkg::LIMIT_W-1:0] limit_t;

  localparam char_t CH_PLUS = 8'h2b;
  localparam char_t CH_NUL  = 8'h00;

  typedef struct packed {
    logic [dtfp_pkg::VALUE_W-1:0]  value;
    logic [dtfp_pkg::STATUS_W-1:0] status;
  } number_t;

  typedef struct {
    string                         text;
    bit                            typed;
    logic [dtfp_pkg::VALUE_W-1:0]  value;
    logic [dtfp_pkg::STATUS_W-1:0] status;
  } text_row_t;

  logic   clk;
  logic   rst_n;
  logic   cfg_we;
  limit_t cfg_wdata;

  dtfp_in_if  in_bus ();
  dtfp_out_if out_bus ();

  decimal_text_to_fixed_point_top u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .out_bus  (out_bus),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // an empty row sends a lone nul marked last
  text_row_t directed_rows [14] = '{
    '{"2",                   1'b1, 31'd536870912,   dtfp_pkg::ST_OK},
    '{"-2",                  1'b1, -31'sd536870912, dtfp_pkg::ST_OK},
    '{"3",                   1'b1, '0,              dtfp_pkg::ST_RANGE},
    '{"+1",                  1'b1, '0,              dtfp_pkg::ST_NODIGIT},
    '{"",                    1'b1, '0,              dtfp_pkg::ST_NODIGIT},
    '{" ",                   1'b1, '0,              dtfp_pkg::ST_NODIGIT},
    '{"-",                   1'b1, '0,              dtfp_pkg::ST_NODIGIT},
    '{"\011 \015-0.5\377",   1'b1, -31'sd134217728, dtfp_pkg::ST_OK},
    '{"1.",                  1'b1, 31'd268435456,   dtfp_pkg::ST_OK},
    '{"1.25x",               1'b1, 31'd335544320,   dtfp_pkg::ST_OK},
    '{"01e9",                1'b0, '0,              dtfp_pkg::ST_OK},
    '{"0.3\2009",            1'b0, '0,              dtfp_pkg::ST_OK},
    '{"1234567890123456789", 1'b1, '0,              dtfp_pkg::ST_RANGE},
    '{"-00.7",               1'b0, '0,              dtfp_pkg::ST_OK}
  };

  limit_t limit_plan [LIMIT_SETTINGS] = '{
    30'd0, 30'd268435456, 30'd536870911, 30'd1, 30'd0, dtfp_pkg::LIMIT_RESET
  };

  number_t results_due [$];
  char_t   text_buf [$];
  int      mismatches;
  int      results_checked;
  int      chars_sent;
  int      numbers_sent;
  int      status_seen [3];
  bit      idle_on;

  // parser model state
  dtfp_pkg::phase_t            scan_phase;
  bit                          scan_negative;
  logic [dtfp_pkg::MANT_W-1:0] scan_mant;
  int                          scan_frac;
  int                          scan_digits;
  limit_t                      limit_model;

  function automatic bit is_decimal(input char_t c);
    return c >= dtfp_pkg::CH_ZERO && c <= dtfp_pkg::CH_NINE;
  endfunction

  function automatic bit is_blank(input char_t c);
    return c == dtfp_pkg::CH_SPACE || (c >= dtfp_pkg::CH_TAB && c <= dtfp_pkg::CH_CR);
  endfunction

  task automatic clear_scan();
    scan_phase    = dtfp_pkg::PH_SKIP;
    scan_negative = 1'b0;
    scan_mant     = '0;
    scan_frac     = 0;
    scan_digits   = 0;
  endtask

  task automatic take_integer_digit(input int d);
    if (scan_mant == '0 && d == 0) return;
    // a significant digit past the limit saturates, forcing out of range
    if (scan_digits >= dtfp_pkg::MAX_DIGITS_DEF) begin
      scan_mant = '1;
      return;
    end
    scan_mant = scan_mant * 10 + d;
    scan_digits++;
  endtask

  task automatic scan_char(input char_t c);
    int d;
    d = int'(c - dtfp_pkg::CH_ZERO);
    // a non-blank, non-minus first character is judged as if after the sign
    if (scan_phase == dtfp_pkg::PH_SKIP && !is_blank(c) && c != dtfp_pkg::CH_MINUS)
      scan_phase = dtfp_pkg::PH_SIGN;
    case (scan_phase)
      dtfp_pkg::PH_SKIP: begin
        if (c == dtfp_pkg::CH_MINUS) begin
          scan_negative = 1'b1;
          scan_phase    = dtfp_pkg::PH_SIGN;
        end
      end
      dtfp_pkg::PH_SIGN: begin
        if (is_decimal(c)) begin
          take_integer_digit(d);
          scan_phase = dtfp_pkg::PH_INT;
        end else begin
          scan_phase = dtfp_pkg::PH_BAD;
        end
      end
      dtfp_pkg::PH_INT: begin
        if (is_decimal(c)) take_integer_digit(d);
        else scan_phase = (c == dtfp_pkg::CH_DOT) ? dtfp_pkg::PH_FRAC : dtfp_pkg::PH_REST;
      end
      dtfp_pkg::PH_FRAC: begin
        if (!is_decimal(c)) begin
          scan_phase = dtfp_pkg::PH_REST;
        end else if (scan_digits < dtfp_pkg::MAX_DIGITS_DEF) begin
          scan_mant = scan_mant * 10 + d;
          scan_digits++;
          scan_frac++;
        end
      end
      default: ;
    endcase
  endtask

  function automatic number_t convert_scan();
    logic [63:0] scale;
    logic [63:0] whole;
    logic [63:0] rest;
    logic [63:0] fbits;
    logic [63:0] q;
    number_t     r;
    r.value  = '0;
    r.status = dtfp_pkg::ST_NODIGIT;
    if (scan_phase == dtfp_pkg::PH_SKIP || scan_phase == dtfp_pkg::PH_SIGN ||
        scan_phase == dtfp_pkg::PH_BAD) return r;
    scale = 64'd1;
    repeat (scan_frac) scale = scale * 10;
    whole = 64'(scan_mant) / scale;
    rest  = 64'(scan_mant) % scale;
    r.status = dtfp_pkg::ST_RANGE;
    if (whole > 64'(limit_model >> dtfp_pkg::FRACTION_BITS_DEF)) return r;
    // restoring long division of the remainder, one fraction bit per pass
    fbits = '0;
    for (int i = 0; i < dtfp_pkg::FRACTION_BITS_DEF; i++) begin
      rest  = rest << 1;
      fbits = fbits << 1;
      if (rest >= scale) begin
        rest     = rest - scale;
        fbits[0] = 1'b1;
      end
    end
    q = (whole << dtfp_pkg::FRACTION_BITS_DEF) + fbits;
    if (q > 64'(limit_model)) return r;
    if (scan_negative) q = -q;
    r.value  = q[dtfp_pkg::VALUE_W-1:0];
    r.status = dtfp_pkg::ST_OK;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("%0t mismatch: %s", $time, msg);
  endtask

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_char(input char_t c, input bit is_last, input bit typed,
                           input number_t typed_result);
    number_t predicted;
    while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid = 1'b1;
    in_bus.ch    = c;
    in_bus.last  = is_last;
    do @(posedge clk); while (!in_bus.ready);
    chars_sent++;
    scan_char(c);
    if (is_last) begin
      predicted = convert_scan();
      clear_scan();
      results_due.push_back(typed ? typed_result : predicted);
      numbers_sent++;
    end
    @(negedge clk);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++)
      send_char(text_buf[i], i == text_buf.size() - 1, 1'b0, '0);
  endtask

  function automatic char_t random_digit();
    // small digits keep most integer parts under the usual limits
    return char_t'(dtfp_pkg::CH_ZERO +
                   (($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : $urandom_range(0, 2)));
  endfunction

  task automatic compose_number();
    int k;
    int n;
    text_buf.delete();
    if ($urandom_range(0, 99) < 80) begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          k = $urandom_range(8, 13);
          text_buf.push_back((k == 8) ? dtfp_pkg::CH_SPACE : char_t'(k));
        end
      end
      if ($urandom_range(0, 1) == 1) text_buf.push_back(dtfp_pkg::CH_MINUS);
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 20)) text_buf.push_back(dtfp_pkg::CH_ZERO);
      k = $urandom_range(0, 99);
      n = (k < 55) ? 1 : (k < 70) ? 0 : (k < 88) ? $urandom_range(2, 4) : $urandom_range(16, 21);
      repeat (n) text_buf.push_back(random_digit());
      if ($urandom_range(0, 3) != 0) begin
        text_buf.push_back(dtfp_pkg::CH_DOT);
        n = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 8) : $urandom_range(15, 22);
        repeat (n) text_buf.push_back(char_t'(dtfp_pkg::CH_ZERO + $urandom_range(0, 9)));
      end
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) text_buf.push_back(char_t'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 7))
          0:       text_buf.push_back(CH_PLUS);
          1:       text_buf.push_back(dtfp_pkg::CH_DOT);
          2:       text_buf.push_back(dtfp_pkg::CH_MINUS);
          3:       text_buf.push_back(dtfp_pkg::CH_SPACE);
          4:       text_buf.push_back(dtfp_pkg::CH_ZERO);
          default: text_buf.push_back(char_t'($urandom_range(0, 255)));
        endcase
      end
    end
    if (text_buf.size() == 0) text_buf.push_back(char_t'($urandom_range(0, 255)));
  endtask

  task automatic write_limit(input limit_t lim);
    cfg_we    = 1'b1;
    cfg_wdata = lim;
    @(negedge clk);
    cfg_we      = 1'b0;
    limit_model = lim;
  endtask

  // drain pending results, then give the divider time to go idle
  task automatic settle();
    while (results_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_bus.ready <= rst_n && (!idle_on || $urandom_range(0, 99) >= IDLE_PERCENT);
  end

  always @(posedge clk) begin
    number_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (results_due.size() == 0) begin
        report_mismatch($sformatf("result value %0d status %0d with no number pending",
                                  $signed(out_bus.value), out_bus.status));
      end else begin
        want = results_due.pop_front();
        results_checked++;
        if (want.status <= dtfp_pkg::ST_RANGE) status_seen[want.status]++;
        if (out_bus.value !== want.value)
          report_mismatch($sformatf("value %0d, want %0d (status %0d)", $signed(out_bus.value),
                                    $signed(want.value), want.status));
        if (out_bus.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_bus.status, want.status));
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: %0d cycles without a transfer, %0d results pending", quiet,
             results_due.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    number_t typed_result;
    limit_t  next_limit;
    int      len;
    int      chars_start;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_bus.valid  = 1'b0;
    in_bus.ch     = '0;
    in_bus.last   = 1'b0;
    out_bus.ready = 1'b0;
    idle_on       = 1'b1;
    mismatches    = 0;
    limit_model   = dtfp_pkg::LIMIT_RESET;
    clear_scan();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[r]) begin
      typed_result = {directed_rows[r].value, directed_rows[r].status};
      len = directed_rows[r].text.len();
      if (len == 0) begin
        send_char(CH_NUL, 1'b1, directed_rows[r].typed, typed_result);
      end else begin
        for (int i = 0; i < len; i++)
          send_char(directed_rows[r].text[i], i == len - 1, directed_rows[r].typed,
                    typed_result);
      end
    end

    for (int s = 0; s < LIMIT_SETTINGS; s++) begin
      in_bus.valid = 1'b0;
      settle();
      next_limit = (s == RANDOM_LIMIT_IDX) ? limit_t'($urandom_range(0, 536870912))
                                           : limit_plan[s];
      write_limit(next_limit);
      // one whole setting runs with both sides at full rate
      idle_on     = (s != QUIET_SETTING);
      chars_start = chars_sent;
      while (chars_sent - chars_start < CHARS_PER_LIMIT) begin
        compose_number();
        send_text();
      end
    end
    in_bus.valid = 1'b0;
    settle();

    $display("%0d characters forming %0d numbers, %0d results compared, %0d magnitude limits",
             chars_sent, numbers_sent, results_checked, LIMIT_SETTINGS + 1);
    $display("status mix: %0d ok, %0d without a digit, %0d out of range, %0d mismatches",
             status_seen[dtfp_pkg::ST_OK], status_seen[dtfp_pkg::ST_NODIGIT],
             status_seen[dtfp_pkg::ST_RANGE], mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
